@@ design/playback_band_limit_and_soft_limit_core_defines.svh @@
// Assertion helpers for the file that checks this block.
`ifndef PLAYBACK_BAND_LIMIT_AND_SOFT_LIMIT_CORE_DEFINES_SVH
`define PLAYBACK_BAND_LIMIT_AND_SOFT_LIMIT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and off during reset.
`define PLBL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("plbl check failed");

// Next-cycle implication, sampled on i_clk and off during reset.
`define PLBL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("plbl check failed");

`endif

@@ design/plbl_pkg.sv @@
package plbl_pkg;

    // Register indexes on the configuration port.
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_HP_COEFF   = 3'd0;
    localparam t_cfg_idx CFG_LP_COEFF   = 3'd1;
    localparam t_cfg_idx CFG_BOOST_GAIN = 3'd2;
    localparam t_cfg_idx CFG_KNEE       = 3'd3;
    localparam t_cfg_idx CFG_MONO_FOLD  = 3'd4;

    // Register reset values, given for 16-bit coefficients and 24-bit samples.
    localparam int HP_COEFF_RST16 = 65350;
    localparam int LP_COEFF_RST16 = 48511;
    localparam int PEAK_RST24     = 8292567;

    // Limiter slope of one fifth in Q0.16.
    localparam int          FIFTH_SHIFT = 16;
    localparam logic [15:0] FIFTH_Q16   = 16'd13107;

    // Multiplier coefficient select.
    typedef logic [2:0] t_bsel;
    localparam t_bsel BSEL_HP    = 3'd0;
    localparam t_bsel BSEL_LP    = 3'd1;
    localparam t_bsel BSEL_NLP   = 3'd2;
    localparam t_bsel BSEL_GAIN  = 3'd3;
    localparam t_bsel BSEL_FIFTH = 3'd4;

    typedef struct packed {
        logic  load;
        t_bsel bsel;
        logic  asel_lp;
        logic  hp_post;
        logic  acc_cap;
        logic  lp_post;
        logic  gn_post;
        logic  lim_prep;
        logic  lim_post;
        logic  fin;
    } t_cmd;

endpackage

@@ design/plbl_in_if.sv @@
interface plbl_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

@@ design/plbl_out_if.sv @@
interface plbl_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          saturated;

    modport source (output valid, output left_out, output right_out, output saturated,
                    input ready);
    modport sink   (input valid, input left_out, input right_out, input saturated,
                    output ready);
endinterface

@@ design/plbl_cfg.sv @@
module plbl_cfg import plbl_pkg::*; #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEFF_BITS  = 16,
    parameter int CFG_W       = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_we,
    input  t_cfg_idx               i_idx,
    input  logic [CFG_W-1:0]       i_data,
    output logic [COEFF_BITS-1:0]  o_hp_coeff,
    output logic [COEFF_BITS-1:0]  o_lp_coeff,
    output logic [COEFF_BITS-1:0]  o_gain,
    output logic [SAMPLE_BITS-2:0] o_peak,
    output logic                   o_mono
);

    localparam int HP_RST_I = (COEFF_BITS >= 16) ? (HP_COEFF_RST16 << (COEFF_BITS - 16))
                                                  : (HP_COEFF_RST16 >> (16 - COEFF_BITS));
    localparam int LP_RST_I = (COEFF_BITS >= 16) ? (LP_COEFF_RST16 << (COEFF_BITS - 16))
                                                  : (LP_COEFF_RST16 >> (16 - COEFF_BITS));
    localparam int PK_RST_I = (SAMPLE_BITS >= 24) ? (PEAK_RST24 << (SAMPLE_BITS - 24))
                                                   : (PEAK_RST24 >> (24 - SAMPLE_BITS));
    localparam logic [COEFF_BITS-1:0]  HP_RST   = COEFF_BITS'(HP_RST_I);
    localparam logic [COEFF_BITS-1:0]  LP_RST   = COEFF_BITS'(LP_RST_I);
    localparam logic [COEFF_BITS-1:0]  GAIN_RST = COEFF_BITS'(64'd1 << (COEFF_BITS - 2));
    localparam logic [SAMPLE_BITS-2:0] PK_RST   = (SAMPLE_BITS - 1)'(PK_RST_I);

    logic [COEFF_BITS-1:0]  r_hp_coeff;
    logic [COEFF_BITS-1:0]  r_lp_coeff;
    logic [COEFF_BITS-1:0]  r_gain;
    logic [SAMPLE_BITS-2:0] r_peak;
    logic                   r_mono;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp_coeff <= HP_RST;
            r_lp_coeff <= LP_RST;
            r_gain     <= GAIN_RST;
            r_peak     <= PK_RST;
            r_mono     <= 1'b0;
        end else if (i_we) begin
            unique case (i_idx)
                CFG_HP_COEFF:   r_hp_coeff <= i_data[COEFF_BITS-1:0];
                CFG_LP_COEFF:   r_lp_coeff <= i_data[COEFF_BITS-1:0];
                CFG_BOOST_GAIN: r_gain     <= i_data[COEFF_BITS-1:0];
                CFG_KNEE:       r_peak     <= i_data[SAMPLE_BITS-2:0];
                CFG_MONO_FOLD:  r_mono     <= i_data[0];
                default: ;
            endcase
        end
    end

    assign o_hp_coeff = r_hp_coeff;
    assign o_lp_coeff = r_lp_coeff;
    assign o_gain     = r_gain;
    assign o_peak     = r_peak;
    assign o_mono     = r_mono;

endmodule

@@ design/plbl_lane.sv @@
module plbl_lane import plbl_pkg::*; #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEFF_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [COEFF_BITS-1:0]         i_hp_coeff,
    input  logic [COEFF_BITS-1:0]         i_lp_coeff,
    input  logic [COEFF_BITS-1:0]         i_gain,
    input  logic [SAMPLE_BITS-2:0]        i_peak,
    output logic signed [SAMPLE_BITS+4:0] o_value
);

    localparam int S  = SAMPLE_BITS;
    localparam int C  = COEFF_BITS;
    localparam int ST = S + 2;
    localparam int WA = S + 5;
    localparam int WB = (C + 2 > 17) ? C + 2 : 17;
    localparam int WP = WA + WB;

    localparam logic signed [WP-1:0] HALF_C = WP'(64'd1 << (C - 1));
    localparam logic signed [WP-1:0] HALF_G = WP'(64'd1 << (C - 3));
    localparam logic signed [WP-1:0] HALF_F = WP'(64'd1 << (FIFTH_SHIFT - 1));
    localparam logic signed [WP-1:0] ST_MAX = WP'((64'd1 << (ST - 1)) - 64'd1);
    localparam logic signed [WP-1:0] ST_MIN = ~ST_MAX;

    function automatic logic signed [ST-1:0] sat_st(input logic signed [WP-1:0] v);
        logic signed [ST-1:0] res;
        if (v > ST_MAX) begin
            res = ST_MAX[ST-1:0];
        end else if (v < ST_MIN) begin
            res = ST_MIN[ST-1:0];
        end else begin
            res = v[ST-1:0];
        end
        return res;
    endfunction

    // Filter history.
    logic signed [S-1:0]  r_hp_in;
    logic signed [ST-1:0] r_hp_out;
    logic signed [ST-1:0] r_lp_out;

    // Working registers.
    logic signed [S-1:0]  r_x;
    logic signed [WA-1:0] r_opa;
    logic signed [WP-1:0] r_prod;
    logic signed [WP-1:0] r_acc;
    logic signed [WA-1:0] r_v;
    logic                 r_pos;
    logic                 r_neg;

    logic signed [WA-1:0] a_op;
    logic signed [WB-1:0] b_op;
    logic signed [WP-1:0] n_prod;
    logic signed [WA-1:0] n_hsum;
    logic [C:0]           nb;
    logic signed [ST-1:0] hp_val;
    logic signed [ST-1:0] lp_val;
    logic signed [WP-1:0] gn_full;
    logic signed [WP-1:0] ex_full;
    logic signed [WA-1:0] lim_s;
    logic                 above;
    logic                 below;

    assign nb = {1'b1, {C{1'b0}}} - {1'b0, i_lp_coeff};

    always_comb begin
        unique case (i_cmd.bsel)
            BSEL_HP:    b_op = $signed({{(WB - C){1'b0}}, i_hp_coeff});
            BSEL_LP:    b_op = $signed({{(WB - C){1'b0}}, i_lp_coeff});
            BSEL_NLP:   b_op = $signed({{(WB - C - 1){1'b0}}, nb});
            BSEL_GAIN:  b_op = $signed({{(WB - C){1'b0}}, i_gain});
            BSEL_FIFTH: b_op = $signed({{(WB - 16){1'b0}}, FIFTH_Q16});
            default:    b_op = '0;
        endcase
    end

    assign a_op   = i_cmd.asel_lp ? $signed({{(WA - ST){r_lp_out[ST-1]}}, r_lp_out})
                                  : r_opa;
    assign n_prod = a_op * b_op;

    assign n_hsum = $signed({{(WA - ST){r_hp_out[ST-1]}}, r_hp_out})
                  + $signed({{(WA - S){i_sample[S-1]}}, i_sample})
                  - $signed({{(WA - S){r_hp_in[S-1]}}, r_hp_in});

    assign hp_val  = sat_st((r_prod + HALF_C) >>> C);
    assign lp_val  = sat_st((r_acc + r_prod + HALF_C) >>> C);
    assign gn_full = (r_prod + HALF_G) >>> (C - 2);
    assign ex_full = (r_prod + HALF_F) >>> FIFTH_SHIFT;

    assign lim_s = $signed({{(WA - S + 1){1'b0}}, i_peak});
    assign above = r_v > lim_s;
    assign below = r_v < -lim_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp_in  <= '0;
            r_hp_out <= '0;
            r_lp_out <= '0;
        end else begin
            if (i_cmd.hp_post) begin
                r_hp_in  <= r_x;
                r_hp_out <= hp_val;
            end
            if (i_cmd.lp_post) begin
                r_lp_out <= lp_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (i_cmd.load) begin
            r_x   <= i_sample;
            r_opa <= n_hsum;
        end
        if (i_cmd.hp_post) begin
            r_opa <= $signed({{(WA - ST){hp_val[ST-1]}}, hp_val});
        end
        if (i_cmd.acc_cap) begin
            r_acc <= r_prod;
        end
        if (i_cmd.lp_post) begin
            r_opa <= $signed({{(WA - ST){lp_val[ST-1]}}, lp_val});
        end
        if (i_cmd.gn_post) begin
            r_v <= gn_full[WA-1:0];
        end
        if (i_cmd.lim_prep) begin
            r_pos <= above;
            r_neg <= below;
            // Excess magnitude over the knee; zero inside the linear range.
            if (above) begin
                r_opa <= r_v - lim_s;
            end else if (below) begin
                r_opa <= -lim_s - r_v;
            end else begin
                r_opa <= '0;
            end
        end
        if (i_cmd.lim_post) begin
            if (r_pos) begin
                r_v <= lim_s + ex_full[WA-1:0];
            end else if (r_neg) begin
                r_v <= -lim_s - ex_full[WA-1:0];
            end
        end
    end

    assign o_value = r_v;

endmodule

@@ design/plbl_out.sv @@
module plbl_out #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic                          i_mono,
    input  logic signed [SAMPLE_BITS+4:0] i_left,
    input  logic signed [SAMPLE_BITS+4:0] i_right,
    input  logic                          i_ready,
    output logic                          o_free,
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_left,
    output logic signed [SAMPLE_BITS-1:0] o_right,
    output logic                          o_sat
);

    localparam int S  = SAMPLE_BITS;
    localparam int WA = S + 5;

    localparam logic signed [WA-1:0] S_MAX = WA'((64'd1 << (S - 1)) - 64'd1);
    localparam logic signed [WA-1:0] S_MIN = ~S_MAX;

    logic                 r_valid;
    logic signed [S-1:0]  r_left;
    logic signed [S-1:0]  r_right;
    logic                 r_sat;

    logic signed [WA:0]   mono_sum;
    logic signed [WA-1:0] mono_val;
    logic signed [WA-1:0] left_sel;
    logic signed [WA-1:0] right_sel;
    logic signed [S-1:0]  left_sat;
    logic signed [S-1:0]  right_sat;
    logic                 left_clip;
    logic                 right_clip;

    assign mono_sum  = $signed({i_left[WA-1], i_left}) + $signed({i_right[WA-1], i_right});
    assign mono_val  = mono_sum[WA:1];
    assign left_sel  = i_mono ? mono_val : i_left;
    assign right_sel = i_mono ? mono_val : i_right;

    always_comb begin
        left_clip = 1'b1;
        if (left_sel > S_MAX) begin
            left_sat = S_MAX[S-1:0];
        end else if (left_sel < S_MIN) begin
            left_sat = S_MIN[S-1:0];
        end else begin
            left_sat  = left_sel[S-1:0];
            left_clip = 1'b0;
        end
        right_clip = 1'b1;
        if (right_sel > S_MAX) begin
            right_sat = S_MAX[S-1:0];
        end else if (right_sel < S_MIN) begin
            right_sat = S_MIN[S-1:0];
        end else begin
            right_sat  = right_sel[S-1:0];
            right_clip = 1'b0;
        end
    end

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_left  <= left_sat;
            r_right <= right_sat;
            r_sat   <= left_clip || right_clip;
        end
    end

    assign o_valid = r_valid;
    assign o_left  = r_left;
    assign o_right = r_right;
    assign o_sat   = r_sat;

endmodule

@@ design/plbl_ctrl.sv @@
module plbl_ctrl import plbl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_free,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MHP  = 4'd1;
    localparam logic [3:0] ST_PHP  = 4'd2;
    localparam logic [3:0] ST_ML1  = 4'd3;
    localparam logic [3:0] ST_ML2  = 4'd4;
    localparam logic [3:0] ST_PLP  = 4'd5;
    localparam logic [3:0] ST_MGN  = 4'd6;
    localparam logic [3:0] ST_PGN  = 4'd7;
    localparam logic [3:0] ST_XLM  = 4'd8;
    localparam logic [3:0] ST_MLM  = 4'd9;
    localparam logic [3:0] ST_PLM  = 4'd10;
    localparam logic [3:0] ST_FIN  = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.bsel = BSEL_HP;
        unique case (r_state)
            ST_IDLE: begin
                cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_MHP;
                end
            end
            ST_MHP: begin
                n_state = ST_PHP;
            end
            ST_PHP: begin
                cmd.hp_post = 1'b1;
                n_state     = ST_ML1;
            end
            ST_ML1: begin
                cmd.bsel = BSEL_LP;
                n_state  = ST_ML2;
            end
            ST_ML2: begin
                // Feed-forward product moves to the accumulator while the
                // feedback term is formed.
                cmd.bsel    = BSEL_NLP;
                cmd.asel_lp = 1'b1;
                cmd.acc_cap = 1'b1;
                n_state     = ST_PLP;
            end
            ST_PLP: begin
                cmd.lp_post = 1'b1;
                n_state     = ST_MGN;
            end
            ST_MGN: begin
                cmd.bsel = BSEL_GAIN;
                n_state  = ST_PGN;
            end
            ST_PGN: begin
                cmd.gn_post = 1'b1;
                n_state     = ST_XLM;
            end
            ST_XLM: begin
                cmd.lim_prep = 1'b1;
                n_state      = ST_MLM;
            end
            ST_MLM: begin
                cmd.bsel = BSEL_FIFTH;
                n_state  = ST_PLM;
            end
            ST_PLM: begin
                cmd.lim_post = 1'b1;
                n_state      = ST_FIN;
            end
            ST_FIN: begin
                if (i_out_free) begin
                    cmd.fin = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cmd      = cmd;

endmodule

@@ design/playback_band_limit_and_soft_limit_core.sv @@
// A frame is accepted only in the idle state, so the input stays closed until the
// frame has been handed to the output register; each lane has
// one multiplier for five products, with rounding, limiter and hand-off steps between.
// A stalled output holds the controller in its hand-off state and closes the input.
// Reset (synchronous, active low) clears the filter history, the controller and
// the output valid, and loads the register defaults; there is no clearing pass.
`include "playback_band_limit_and_soft_limit_core_defines.svh"

module playback_band_limit_and_soft_limit_core import plbl_pkg::*; #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEFF_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    plbl_in_if.sink              i_in,
    plbl_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  t_cfg_idx             i_cfg_idx,
    input  logic [((COEFF_BITS > SAMPLE_BITS - 1) ? COEFF_BITS : SAMPLE_BITS - 1)-1:0]
                                 i_cfg_data
);

    localparam int CFG_W = (COEFF_BITS > SAMPLE_BITS - 1) ? COEFF_BITS : SAMPLE_BITS - 1;

    logic [COEFF_BITS-1:0]         hp_coeff;
    logic [COEFF_BITS-1:0]         lp_coeff;
    logic [COEFF_BITS-1:0]         boost_gain;
    logic [SAMPLE_BITS-2:0]        knee_level;
    logic                          mono_fold;
    t_cmd                          cmd;
    logic                          out_free;
    logic signed [SAMPLE_BITS+4:0] left_val;
    logic signed [SAMPLE_BITS+4:0] right_val;
    logic [7:0]                    cmd_steps;

    plbl_cfg #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS),
        .CFG_W       (CFG_W)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (i_cfg_we),
        .i_idx      (i_cfg_idx),
        .i_data     (i_cfg_data),
        .o_hp_coeff (hp_coeff),
        .o_lp_coeff (lp_coeff),
        .o_gain     (boost_gain),
        .o_peak     (knee_level),
        .o_mono     (mono_fold)
    );

    plbl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (out_free),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    plbl_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS)
    ) u_lane_left (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_sample   (i_in.left_sample),
        .i_hp_coeff (hp_coeff),
        .i_lp_coeff (lp_coeff),
        .i_gain     (boost_gain),
        .i_peak     (knee_level),
        .o_value    (left_val)
    );

    plbl_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS)
    ) u_lane_right (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_sample   (i_in.right_sample),
        .i_hp_coeff (hp_coeff),
        .i_lp_coeff (lp_coeff),
        .i_gain     (boost_gain),
        .i_peak     (knee_level),
        .o_value    (right_val)
    );

    plbl_out #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (cmd.fin),
        .i_mono  (mono_fold),
        .i_left  (left_val),
        .i_right (right_val),
        .i_ready (o_out.ready),
        .o_free  (out_free),
        .o_valid (o_out.valid),
        .o_left  (o_out.left_out),
        .o_right (o_out.right_out),
        .o_sat   (o_out.saturated)
    );

    assign cmd_steps = {cmd.load, cmd.hp_post, cmd.acc_cap, cmd.lp_post,
                        cmd.gn_post, cmd.lim_prep, cmd.lim_post, cmd.fin};

    // A frame in flight keeps the input closed on the following cycle.
    `PLBL_ASSERT_NEXT(a_busy_after_accept, i_in.valid && i_in.ready, !i_in.ready)
    // The finished frame is only written when the output register can take it.
    `PLBL_ASSERT_NOW(a_fin_into_free, cmd.fin, out_free)
    // At most one datapath step is commanded in any cycle.
    `PLBL_ASSERT_NOW(a_one_step, 1'b1, $onehot0(cmd_steps))

endmodule
